>>> sv/itdt_pkg.sv
// itdt_pkg: shared types, character codes and helpers for the decimal text converter
// no dependencies; imported by itdt_bcd, integer_to_decimal_text and tb_top
package itdt_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [3:0] BCD_LIMIT  = 4'd5;
    localparam logic [3:0] BCD_ADJUST = 4'd3;
    localparam logic [3:0] DIGIT_MAX  = 4'd9;

    // handoff from the converter to the character emitter
    typedef struct packed {
        logic valid;
        logic negative;
    } conv_status_t;

    typedef enum logic [1:0] {
        EMIT_IDLE,
        EMIT_SIGN,
        EMIT_DIGIT
    } emit_state_t;

    // double-dabble correction of one bcd digit before the next shift
    function automatic logic [3:0] bcd_adjust(input logic [3:0] digit);
        bcd_adjust = (digit >= BCD_LIMIT) ? digit + BCD_ADJUST : digit;
    endfunction

endpackage

>>> sv/itdt_bcd.sv
// itdt_bcd: bit-serial binary to bcd converter (shift and add-3), one magnitude bit per cycle
// depends on itdt_pkg
module itdt_bcd import itdt_pkg::*; #(
    parameter int VALUE_BITS = 32,
    parameter int DIGITS     = 10
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [VALUE_BITS-1:0]   in_value,
    output conv_status_t            status,
    output logic [DIGITS*4-1:0]     bcd,
    input  logic                    take
);

    localparam int CNT_W = $clog2(VALUE_BITS + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic                  neg_reg, neg_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [DIGITS*4-1:0]   bcd_reg, bcd_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIGITS*4-1:0]   bcd_adj;
    logic                  accept;

    assign in_ready = !busy_reg && !done_reg;
    assign accept   = in_valid && in_ready;

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            bcd_adj[4*i +: 4] = bcd_adjust(bcd_reg[4*i +: 4]);
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = done_reg;
        neg_next  = neg_reg;
        mag_next  = mag_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        if (accept) begin
            neg_next  = in_value[VALUE_BITS-1];
            mag_next  = in_value[VALUE_BITS-1] ? (~in_value + VALUE_BITS'(1)) : in_value;
            bcd_next  = '0;
            cnt_next  = CNT_W'(VALUE_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // magnitude enters msb first into the corrected bcd word
            bcd_next = {bcd_adj[DIGITS*4-2:0], mag_reg[VALUE_BITS-1]};
            mag_next = {mag_reg[VALUE_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (done_reg && take) begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        neg_reg <= neg_next;
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
    end

    assign status.valid    = done_reg;
    assign status.negative = neg_reg;
    assign bcd             = bcd_reg;

endmodule

>>> sv/integer_to_decimal_text.sv
// integer_to_decimal_text: signed integer to decimal ascii, one character per output request
// the value is converted one magnitude bit per cycle in itdt_bcd, then its bcd digits pass to
// the emitter, which skips leading zeros and sends the sign and digits; a new request is taken
// as soon as the emitter has taken the previous digits, so it is converted while characters of
// the previous number leave from the output register, one per cycle while output is not stalled
// reset: synchronous active-low aresetn clears all handshake and sequencing state
module integer_to_decimal_text import itdt_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata,  // value
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [7:0]                        m_axis_tdata,  // text_char
    output logic                              m_axis_tlast   // last_char
);

    // upper bound on decimal digits of 2^(VALUE_BITS-1)
    localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int LEFT_W = $clog2(DIGITS + 1);

    conv_status_t        conv_status;
    logic [DIGITS*4-1:0] conv_bcd;
    logic                conv_take;

    emit_state_t         state_reg, state_next;
    logic [DIGITS*4-1:0] digits_reg, digits_next;
    logic [LEFT_W-1:0]   left_reg, left_next;
    logic                lead_reg, lead_next;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;
    logic [3:0]          top_digit;
    logic                out_free;
    logic                skip_zero;
    logic                emit_sign;
    logic                emit_digit;
    logic                final_digit;

    itdt_bcd #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_bcd (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_value (s_axis_tdata[VALUE_BITS-1:0]),
        .status   (conv_status),
        .bcd      (conv_bcd),
        .take     (conv_take)
    );

    assign top_digit   = digits_reg[DIGITS*4-1 -: 4];
    assign out_free    = !m_valid_reg || m_axis_tready;
    assign final_digit = (left_reg == LEFT_W'(1));
    // leading zeros are dropped, but the units digit always goes out
    assign skip_zero   = lead_reg && (top_digit == 4'd0) && !final_digit;
    assign emit_sign   = (state_reg == EMIT_SIGN) && out_free;
    assign emit_digit  = (state_reg == EMIT_DIGIT) && !skip_zero && out_free;
    assign conv_take   = (state_reg == EMIT_IDLE) && conv_status.valid;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            EMIT_IDLE: begin
                if (conv_status.valid) begin
                    state_next = conv_status.negative ? EMIT_SIGN : EMIT_DIGIT;
                end
            end
            EMIT_SIGN: begin
                if (out_free) begin
                    state_next = EMIT_DIGIT;
                end
            end
            EMIT_DIGIT: begin
                if (emit_digit && final_digit) begin
                    state_next = EMIT_IDLE;
                end
            end
            default: begin
                state_next = EMIT_IDLE;
            end
        endcase
    end

    always_comb begin
        digits_next  = digits_reg;
        left_next    = left_reg;
        lead_next    = lead_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (conv_take) begin
            digits_next = conv_bcd;
            left_next   = LEFT_W'(DIGITS);
            lead_next   = 1'b1;
        end else if (emit_sign) begin
            m_valid_next = 1'b1;
            m_data_next  = CHAR_MINUS;
            m_last_next  = 1'b0;
        end else if (state_reg == EMIT_DIGIT && (skip_zero || emit_digit)) begin
            digits_next = {digits_reg[DIGITS*4-5:0], 4'd0};
            left_next   = left_reg - LEFT_W'(1);
            if (emit_digit) begin
                lead_next    = 1'b0;
                m_valid_next = 1'b1;
                m_data_next  = CHAR_ZERO + {4'd0, top_digit};
                m_last_next  = final_digit;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= EMIT_IDLE;
            m_valid_reg <= 1'b0;
            left_reg    <= '0;
            lead_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            left_reg    <= left_next;
            lead_reg    <= lead_next;
        end
        digits_reg <= digits_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tdata == CHAR_MINUS) ||
            ((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_ZERO + {4'd0, DIGIT_MAX})))
        else $error("illegal character on output");

    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tdata == CHAR_MINUS) |-> !m_axis_tlast)
        else $error("minus sign flagged as last character");

    a_digits_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == EMIT_DIGIT) |-> (left_reg != '0))
        else $error("digit phase with no digits left");

    a_sign_then_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_sign |=> (state_reg == EMIT_DIGIT) && lead_reg)
        else $error("minus sign not followed by digit phase");

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking bench for integer_to_decimal_text, signed 32-bit value in, ascii text out
// predicts the character stream per input request and compares each output request in order
// depends on itdt_pkg and integer_to_decimal_text
module tb_top;
    import itdt_pkg::*;

    localparam int VALUE_BITS = 32;
    localparam int IDLE_PCT   = 20;
    localparam int DRAIN_WAIT = VALUE_BITS + 16;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last_char;
    } text_beat_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    logic [31:0] pending_values[$];
    text_beat_t  expected_text[$];
    int          n_values;
    int          n_taken  = 0;
    int          n_errors = 0;
    int          n_cycles = 0;
    logic        value_taken = 1'b0;
    logic        quiet;

    integer_to_decimal_text #(.VALUE_BITS(VALUE_BITS)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // value
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // text_char
        .m_axis_tlast  (m_axis_tlast)    // last_char
    );

    always #2 aclk = ~aclk;

    // a long window with no idling on either side
    assign quiet = (n_cycles >= 3000) && (n_cycles < 6000);

    // queue the characters that one signed value turns into
    function automatic void push_decimal_text(input logic [31:0] value);
        longint     signed_val;
        longint     mag;
        logic [7:0] digits[$];
        text_beat_t beat;
        signed_val = longint'($signed(value));
        mag = (signed_val < 0) ? -signed_val : signed_val;
        if (mag == 0) begin
            digits.push_front(CHAR_ZERO);
        end
        while (mag != 0) begin
            digits.push_front(CHAR_ZERO + 8'(mag % 10));
            mag = mag / 10;
        end
        if (signed_val < 0) begin
            beat.text_char = CHAR_MINUS;
            beat.last_char = 1'b0;
            expected_text.push_back(beat);
        end
        foreach (digits[i]) begin
            beat.text_char = digits[i];
            beat.last_char = (i == digits.size() - 1);
            expected_text.push_back(beat);
        end
    endfunction

    // random value with a chosen number of decimal digits and a random sign
    function automatic logic [31:0] value_with_digits(input int ndig);
        longint lo;
        longint hi;
        longint mag;
        lo = 1;
        for (int i = 1; i < ndig; i++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (ndig == 1) lo = 0;
        if (hi > 64'd2147483648) hi = 64'd2147483648;
        mag = lo + longint'({$urandom, $urandom}) % (hi - lo + 1);
        if (mag < 0) mag = -mag % (hi - lo + 1) + lo;
        if ($urandom_range(1) == 1) begin
            return 32'(-mag);
        end
        if (mag > 64'd2147483647) mag = 64'd2147483647;
        return 32'(mag);
    endfunction

    // driver: requests change on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            n_cycles <= n_cycles + 1;
            if (!s_axis_tvalid || value_taken) begin
                if (pending_values.size() != 0 &&
                    (quiet || $urandom_range(99) >= IDLE_PCT)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pending_values.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // monitor: both channels sampled on the rising edge
    always @(posedge aclk) begin
        text_beat_t want;
        if (!aresetn) begin
            value_taken <= 1'b0;
        end else begin
            value_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                push_decimal_text(s_axis_tdata);
                n_taken <= n_taken + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_text.size() == 0) begin
                    $error("unexpected output request: text_char %h last_char %b",
                           m_axis_tdata, m_axis_tlast);
                    n_errors = n_errors + 1;
                end else begin
                    want = expected_text.pop_front();
                    if (m_axis_tdata !== want.text_char) begin
                        $error("text_char expected %h actual %h", want.text_char, m_axis_tdata);
                        n_errors = n_errors + 1;
                    end
                    if (m_axis_tlast !== want.last_char) begin
                        $error("last_char expected %b actual %b", want.last_char, m_axis_tlast);
                        n_errors = n_errors + 1;
                    end
                end
            end
        end
    end

    initial begin
        logic [31:0] directed[] = '{
            32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
            32'd999999999, -32'sd999999999, 32'd1234567890, -32'sd5, 32'd7,
            32'h5555_5555, 32'hAAAA_AAAA, 32'd4294, -32'sd1000000000
        };
        foreach (directed[i]) pending_values.push_back(directed[i]);
        for (int i = 0; i < 320; i++) begin
            case ($urandom_range(9))
                0, 1, 2, 3: pending_values.push_back($urandom);
                4, 5, 6, 7: pending_values.push_back(value_with_digits($urandom_range(1, 10)));
                default:    pending_values.push_back(32'($signed($urandom_range(40)) - 20));
            endcase
        end
        n_values = pending_values.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        wait (n_taken == n_values && expected_text.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (n_errors == 0 && expected_text.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
